[hdl/text_terminal_line_buffer_macros.svh]
// Assertion macros used by the terminal line buffer top level.
`ifndef TEXT_TERMINAL_LINE_BUFFER_MACROS_SVH
`define TEXT_TERMINAL_LINE_BUFFER_MACROS_SVH

`ifndef SYNTH

// Check a property on every clock edge outside reset.
`define TTLB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a trigger is followed by a condition on the next edge.
`define TTLB_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`else

`define TTLB_ASSERT(lbl, prop, msg)
`define TTLB_ASSERT_NEXT(lbl, trig, cond, msg)

`endif

`endif

[hdl/ttlb_pkg.sv]
// Package with sizes, codes and control types of the terminal line buffer.
package ttlb_pkg;

    localparam int ROWS    = 20;
    localparam int COLUMNS = 80;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = $clog2(ROWS * COLUMNS);

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;

    typedef enum logic [1:0] {
        OP_WRITE     = 2'd0,
        OP_BACKSPACE = 2'd1,
        OP_READ      = 2'd2,
        OP_NOP       = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FETCH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic fetch;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_read;
        logic out_free;
    } ctrl_status_t;

endpackage

[hdl/ttlb_in_if.sv]
// Request channel of the terminal line buffer.
interface ttlb_in_if
    import ttlb_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [BYTE_W-1:0] char_byte;
    logic [ROW_W-1:0]  view_row;
    logic [COL_W-1:0]  view_col;

    modport source (
        output valid, opcode, char_byte, view_row, view_col,
        input  ready
    );

    modport sink (
        input  valid, opcode, char_byte, view_row, view_col,
        output ready
    );
endinterface

[hdl/ttlb_out_if.sv]
// Result channel of the terminal line buffer.
interface ttlb_out_if
    import ttlb_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] cell_byte;
    logic              row_shown;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic              screen_full;

    modport source (
        output valid, cell_byte, row_shown, cursor_row, cursor_col, screen_full,
        input  ready
    );

    modport sink (
        input  valid, cell_byte, row_shown, cursor_row, cursor_col, screen_full,
        output ready
    );
endinterface

[hdl/ttlb_ctrl.sv]
// Sequencing state machine of the terminal line buffer.
module ttlb_ctrl
    import ttlb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // Hold the current step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through capture, execute, fetch (reads only) and result
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = status.is_read ? ST_FETCH : ST_DONE;
            end
            ST_FETCH:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drive handshake and datapath commands
    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            ST_FETCH:
            begin
                cmd.fetch = 1'b1;
            end
            ST_DONE:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

[hdl/ttlb_datapath.sv]
// Cell memory, line lengths, cursor and result register of the line buffer.
module ttlb_datapath
    import ttlb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_cmd_t         cmd,
    output ctrl_status_t      status,
    input  logic [1:0]        opcode,
    input  logic [BYTE_W-1:0] char_byte,
    input  logic [ROW_W-1:0]  view_row,
    input  logic [COL_W-1:0]  view_col,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [BYTE_W-1:0] cell_byte,
    output logic              row_shown,
    output logic [ROW_W-1:0]  cursor_row,
    output logic [COL_W-1:0]  cursor_col,
    output logic              screen_full
);

    // Captured request
    op_t               op_reg;
    logic [BYTE_W-1:0] char_reg;
    logic [ROW_W-1:0]  vrow_reg;
    logic [COL_W-1:0]  vcol_reg;

    // Cursor and line state
    logic [ROW_W-1:0]  line_reg;
    logic [ROW_W-1:0]  line_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic              wrapped_reg;
    logic              wrapped_next;
    logic [COL_W-1:0]  len_reg  [ROWS];
    logic [COL_W-1:0]  len_next [ROWS];
    logic              advance;
    logic              last_line;

    // Read path
    logic [ROW_W:0]    rot_sum;
    logic [ROW_W-1:0]  rot_phys;
    logic              shown;
    logic [ROW_W-1:0]  phys;
    logic              hit;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic              shown_reg;
    logic              hit_reg;
    logic [BYTE_W-1:0] rd_data_reg;

    // Cell memory
    logic [BYTE_W-1:0] mem [ROWS * COLUMNS];
    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr;

    // Result register
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_cell_reg;
    logic              out_shown_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic              out_full_reg;

    assign status.is_read  = (op_reg == OP_READ);
    assign status.out_free = !out_valid_reg || out_ready;

    // Capture the request fields
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= op_t'(opcode);
            char_reg <= char_byte;
            vrow_reg <= view_row;
            vcol_reg <= view_col;
        end
    end

    // Map a screen row to its physical line
    always_comb
    begin
        rot_sum = {1'b0, line_reg} + (ROW_W+1)'(1) + {1'b0, vrow_reg};
        if (rot_sum >= (ROW_W+1)'(ROWS))
        begin
            rot_phys = ROW_W'(rot_sum - (ROW_W+1)'(ROWS));
        end
        else
        begin
            rot_phys = ROW_W'(rot_sum);
        end
        if (wrapped_reg)
        begin
            shown = (vrow_reg < ROW_W'(ROWS));
            phys  = shown ? rot_phys : '0;
        end
        else
        begin
            shown = (vrow_reg <= line_reg);
            phys  = shown ? vrow_reg : '0;
        end
        hit = shown && (vcol_reg < len_reg[phys]);
    end

    // Cursor update for write and backspace
    assign last_line = (line_reg == ROW_W'(ROWS - 1));

    always_comb
    begin
        line_next    = line_reg;
        col_next     = col_reg;
        wrapped_next = wrapped_reg;
        len_next     = len_reg;
        mem_we       = 1'b0;
        advance      = 1'b0;
        if (cmd.exec)
        begin
            case (op_reg)
                OP_WRITE:
                begin
                    if (char_reg == NEWLINE_BYTE)
                    begin
                        advance = 1'b1;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        if (col_reg == COL_W'(COLUMNS - 1))
                        begin
                            len_next[line_reg] = COL_W'(COLUMNS);
                            advance            = 1'b1;
                        end
                        else
                        begin
                            col_next           = col_reg + COL_W'(1);
                            len_next[line_reg] = col_reg + COL_W'(1);
                        end
                    end
                end
                OP_BACKSPACE:
                begin
                    if (col_reg != '0)
                    begin
                        col_next           = col_reg - COL_W'(1);
                        len_next[line_reg] = col_reg - COL_W'(1);
                    end
                end
                default:
                begin
                    mem_we = 1'b0;
                end
            endcase
        end
        // Move to column zero of the next line and empty it
        if (advance)
        begin
            line_next           = last_line ? '0 : line_reg + ROW_W'(1);
            wrapped_next        = wrapped_reg || last_line;
            col_next            = '0;
            len_next[line_next] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg    <= '0;
            col_reg     <= '0;
            wrapped_reg <= 1'b0;
            for (int i = 0; i < ROWS; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else
        begin
            line_reg    <= line_next;
            col_reg     <= col_next;
            wrapped_reg <= wrapped_next;
            len_reg     <= len_next;
        end
    end

    // Register the read address and masks
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            rd_addr_reg <= ADDR_W'(ADDR_W'(phys) * ADDR_W'(COLUMNS) + ADDR_W'(vcol_reg));
            shown_reg   <= shown;
            hit_reg     <= hit;
        end
    end

    assign wr_addr = ADDR_W'(ADDR_W'(line_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg));

    // Write and read the cell memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= char_reg;
        end
        if (cmd.fetch)
        begin
            rd_data_reg <= mem[rd_addr_reg];
        end
    end

    // Load the result and hold it until the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_cell_reg  <= '0;
            out_shown_reg <= 1'b0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            out_full_reg  <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
            out_cell_reg  <= (status.is_read && hit_reg) ? rd_data_reg : '0;
            out_shown_reg <= status.is_read && shown_reg;
            out_row_reg   <= line_reg;
            out_col_reg   <= col_reg;
            out_full_reg  <= wrapped_reg;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cell_byte   = out_cell_reg;
    assign row_shown   = out_shown_reg;
    assign cursor_row  = out_row_reg;
    assign cursor_col  = out_col_reg;
    assign screen_full = out_full_reg;

endmodule

[hdl/text_terminal_line_buffer.sv]
// Top level of the text terminal line buffer.
// Usage:
//   in_ch carries one request per transfer: opcode 0 writes char_byte at the
//   cursor (byte 10 starts a new line), 1 is backspace, 2 reads the cell at
//   view_row/view_col in display order (oldest line on top once the ring has
//   wrapped), 3 does nothing.
//   out_ch carries exactly one result per request: the read byte and whether
//   the row is shown (both zero for non-reads), the cursor after the step and
//   the sticky screen_full flag.
// Sequencing: one request at a time, set by the controller: capture,
//   execute, fetch (reads only, for the registered read port of the cell
//   memory), result.
// Reset clears the cursor, line lengths and the full flag at once; the cell
//   memory is not cleared, since line lengths mask every unwritten cell.
// A stalled receiver holds the result; the next request is still taken and
//   runs up to its result step, where it waits for the transfer.
`include "text_terminal_line_buffer_macros.svh"

module text_terminal_line_buffer
    import ttlb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ttlb_in_if.sink    in_ch,
    ttlb_out_if.source out_ch
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    ttlb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    ttlb_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .opcode      (in_ch.opcode),
        .char_byte   (in_ch.char_byte),
        .view_row    (in_ch.view_row),
        .view_col    (in_ch.view_col),
        .out_ready   (out_ch.ready),
        .out_valid   (out_ch.valid),
        .cell_byte   (out_ch.cell_byte),
        .row_shown   (out_ch.row_shown),
        .cursor_row  (out_ch.cursor_row),
        .cursor_col  (out_ch.cursor_col),
        .screen_full (out_ch.screen_full)
    );

    // Only one request in flight
    `TTLB_ASSERT_NEXT(a_one_in_flight, in_ch.valid && in_ch.ready, !in_ch.ready, "second request taken while busy")
    // Cursor stays on the screen
    `TTLB_ASSERT(a_cursor_range, !out_ch.valid || (out_ch.cursor_col < COL_W'(COLUMNS) && out_ch.cursor_row < ROW_W'(ROWS)), "cursor out of range")
    // A hidden row never returns data
    `TTLB_ASSERT(a_hidden_zero, !out_ch.valid || out_ch.row_shown || out_ch.cell_byte == '0, "data from a hidden row")
    // Full flag is sticky
    `TTLB_ASSERT(a_full_sticky, !$fell(out_ch.screen_full), "screen_full dropped")

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the text terminal line buffer: directed table, then random traffic.
module tb_top
    import ttlb_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 600;
    localparam int TAIL_ITEMS   = 80;
    localparam int HOLD_AT_ITEM = 80;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 10;
    localparam int LIMIT_CYCLES = 200000;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] ch;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } term_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] cbyte;
        logic              shown;
        logic [ROW_W-1:0]  crow;
        logic [COL_W-1:0]  ccol;
        logic              full;
    } screen_report_t;

    typedef struct packed {
        term_req_t      req;
        logic           pinned;
        screen_report_t rep;
    } script_row_t;

    // Directed rows; pinned rows carry their result, the rest use the shadow terminal
    localparam int SCRIPT_LEN = 22;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{'{OP_READ,      8'h00, 5'd0,  7'd0},   1'b1, '{8'h00, 1'b1, 5'd0, 7'd0, 1'b0}},
        '{'{OP_READ,      8'hFF, 5'd1,  7'd0},   1'b1, '{8'h00, 1'b0, 5'd0, 7'd0, 1'b0}},
        '{'{OP_READ,      8'h00, 5'd31, 7'd127}, 1'b1, '{8'h00, 1'b0, 5'd0, 7'd0, 1'b0}},
        '{'{OP_BACKSPACE, 8'hFF, 5'd31, 7'd127}, 1'b1, '{8'h00, 1'b0, 5'd0, 7'd0, 1'b0}},
        '{'{OP_NOP,       8'hFF, 5'd31, 7'd127}, 1'b1, '{8'h00, 1'b0, 5'd0, 7'd0, 1'b0}},
        '{'{OP_WRITE,     8'h00, 5'd0,  7'd0},   1'b1, '{8'h00, 1'b0, 5'd0, 7'd1, 1'b0}},
        '{'{OP_WRITE,     8'hFF, 5'd31, 7'd127}, 1'b1, '{8'h00, 1'b0, 5'd0, 7'd2, 1'b0}},
        '{'{OP_WRITE,     8'h0A, 5'd0,  7'd0},   1'b1, '{8'h00, 1'b0, 5'd1, 7'd0, 1'b0}},
        '{'{OP_READ,      8'h00, 5'd0,  7'd0},   1'b0, '0},
        '{'{OP_READ,      8'h00, 5'd0,  7'd1},   1'b0, '0},
        '{'{OP_READ,      8'h00, 5'd0,  7'd2},   1'b1, '{8'h00, 1'b1, 5'd1, 7'd0, 1'b0}},
        '{'{OP_READ,      8'h00, 5'd0,  7'd127}, 1'b1, '{8'h00, 1'b1, 5'd1, 7'd0, 1'b0}},
        '{'{OP_WRITE,     8'h41, 5'd5,  7'd9},   1'b0, '0},
        '{'{OP_WRITE,     8'h7E, 5'd0,  7'd0},   1'b0, '0},
        '{'{OP_BACKSPACE, 8'h00, 5'd0,  7'd0},   1'b0, '0},
        '{'{OP_READ,      8'h00, 5'd1,  7'd0},   1'b0, '0},
        '{'{OP_READ,      8'h00, 5'd1,  7'd1},   1'b0, '0},
        '{'{OP_READ,      8'h00, 5'd2,  7'd0},   1'b1, '{8'h00, 1'b0, 5'd1, 7'd1, 1'b0}},
        '{'{OP_WRITE,     8'h80, 5'd0,  7'd0},   1'b0, '0},
        '{'{OP_NOP,       8'h00, 5'd0,  7'd0},   1'b0, '0},
        '{'{OP_BACKSPACE, 8'h00, 5'd0,  7'd0},   1'b0, '0},
        '{'{OP_READ,      8'h00, 5'd1,  7'd1},   1'b0, '0}
    };

    logic clk;
    logic rst_n;

    ttlb_in_if  in_ch ();
    ttlb_out_if out_ch ();

    text_terminal_line_buffer i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Shadow terminal state
    logic [BYTE_W-1:0] shadow_cells [ROWS][COLUMNS];
    int                line_lens [ROWS];
    int                cursor_line;
    int                cursor_column;
    bit                ring_wrapped;

    screen_report_t screen_reports [$];
    int             mismatches;
    int             items_accepted;
    int             work_items;
    int             cycle_count;
    int             send_gap_pct;
    bit             calm_tail;

    // Move the cursor to the start of the next line and empty that line
    function automatic void advance_line();
        cursor_line++;
        if (cursor_line >= ROWS)
        begin
            cursor_line  = 0;
            ring_wrapped = 1'b1;
        end
        cursor_column          = 0;
        line_lens[cursor_line] = 0;
        for (int c = 0; c < COLUMNS; c++)
            shadow_cells[cursor_line][c] = '0;
    endfunction

    // Apply one request to the shadow terminal and return the report it yields
    function automatic screen_report_t apply_terminal_op(term_req_t req);
        screen_report_t rep;
        int             phys;
        rep  = '0;
        phys = 0;
        case (req.op)
            OP_WRITE:
            begin
                if (req.ch == NEWLINE_BYTE)
                    advance_line();
                else
                begin
                    shadow_cells[cursor_line][cursor_column] = req.ch;
                    cursor_column++;
                    line_lens[cursor_line] = cursor_column;
                    if (cursor_column >= COLUMNS)
                        advance_line();
                end
            end
            OP_BACKSPACE:
            begin
                if (cursor_column > 0)
                begin
                    cursor_column--;
                    shadow_cells[cursor_line][cursor_column] = '0;
                    line_lens[cursor_line] = cursor_column;
                end
            end
            OP_READ:
            begin
                if (ring_wrapped)
                begin
                    if (int'(req.row) < ROWS)
                    begin
                        rep.shown = 1'b1;
                        phys      = (cursor_line + 1 + int'(req.row)) % ROWS;
                    end
                end
                else if (int'(req.row) <= cursor_line)
                begin
                    rep.shown = 1'b1;
                    phys      = int'(req.row);
                end
                if (rep.shown && int'(req.col) < line_lens[phys])
                    rep.cbyte = shadow_cells[phys][req.col];
            end
            default: ;
        endcase
        rep.crow = ROW_W'(cursor_line);
        rep.ccol = COL_W'(cursor_column);
        rep.full = ring_wrapped;
        return rep;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Offer one request, hold it until the transfer, then record what it should yield
    task automatic transfer_request(input term_req_t req, input bit pinned,
                                    input screen_report_t pinned_rep);
        screen_report_t rep;
        if ($urandom_range(0, 31) == 0)
            send_gap_pct = 20 * $urandom_range(0, 2);
        if (!calm_tail && $urandom_range(0, 99) < send_gap_pct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.opcode    <= req.op;
        in_ch.char_byte <= req.ch;
        in_ch.view_row  <= req.row;
        in_ch.view_col  <= req.col;
        do
            @(posedge clk);
        while (!in_ch.ready);
        rep = apply_terminal_op(req);
        screen_reports.push_back(pinned ? pinned_rep : rep);
        items_accepted++;
        if (req.op != OP_NOP)
            work_items++;
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Timeout
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off, no stalls at the tail
    initial
    begin
        int  stall_pct;
        bit  hold_done;
        stall_pct = 0;
        hold_done = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 63) == 0)
                stall_pct = 15 * $urandom_range(0, 2);
            if (!hold_done && items_accepted >= HOLD_AT_ITEM)
            begin
                hold_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm_tail && $urandom_range(0, 99) < stall_pct)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare every result transfer with the oldest pending report
    always @(posedge clk)
    begin : result_check
        screen_report_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (screen_reports.size() == 0)
            begin
                $error("result transfer with no request pending");
                mismatches++;
            end
            else
            begin
                want = screen_reports.pop_front();
                check_field("cell_byte", want.cbyte, out_ch.cell_byte);
                check_field("row_shown", 8'(want.shown), 8'(out_ch.row_shown));
                check_field("cursor_row", 8'(want.crow), 8'(out_ch.cursor_row));
                check_field("cursor_col", 8'(want.ccol), 8'(out_ch.cursor_col));
                check_field("screen_full", 8'(want.full), 8'(out_ch.screen_full));
            end
        end
    end

    // Stimulus
    initial
    begin
        term_req_t req;
        int        random_base;
        int        burst;
        int        count;
        int        visible;
        int        phys;

        mismatches     = 0;
        items_accepted = 0;
        work_items     = 0;
        send_gap_pct   = 20;
        calm_tail      = 1'b0;
        cursor_line    = 0;
        cursor_column  = 0;
        ring_wrapped   = 1'b0;
        foreach (line_lens[r])
            line_lens[r] = 0;
        foreach (shadow_cells[r, c])
            shadow_cells[r][c] = '0;

        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.opcode    <= OP_NOP;
        in_ch.char_byte <= '0;
        in_ch.view_row  <= '0;
        in_ch.view_col  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (int i = 0; i < SCRIPT_LEN; i++)
            transfer_request(SCRIPT[i].req, SCRIPT[i].pinned, SCRIPT[i].rep);

        // Random traffic in bursts of typed text, full lines, newlines, reads and noise
        random_base = work_items;
        while (work_items - random_base < RANDOM_ITEMS)
        begin
            burst = $urandom_range(0, 9);
            case (burst)
                0, 1, 2, 3: count = $urandom_range(1, 15);
                4:          count = $urandom_range(COLUMNS - 10, COLUMNS);
                5:          count = $urandom_range(1, 6);
                6, 7, 8:    count = $urandom_range(1, 10);
                default:    count = $urandom_range(1, 5);
            endcase
            for (int k = 0; k < count; k++)
            begin
                calm_tail = (work_items - random_base) >= RANDOM_ITEMS - TAIL_ITEMS;
                req.op  = OP_WRITE;
                req.ch  = BYTE_W'($urandom());
                req.row = ROW_W'($urandom());
                req.col = COL_W'($urandom());
                case (burst)
                    0, 1, 2, 3:
                    begin
                        case ($urandom_range(0, 9))
                            0:       req.op = OP_BACKSPACE;
                            1:       req.ch = NEWLINE_BYTE;
                            default: ;
                        endcase
                    end
                    4:
                    begin
                        while (req.ch == NEWLINE_BYTE)
                            req.ch = BYTE_W'($urandom());
                    end
                    5:
                        req.ch = NEWLINE_BYTE;
                    6, 7, 8:
                    begin
                        req.op = OP_READ;
                        // Aim most reads at shown rows and near the written length
                        if ($urandom_range(0, 4) != 0)
                        begin
                            visible = ring_wrapped ? ROWS : cursor_line + 1;
                            req.row = ROW_W'($urandom_range(0, visible - 1));
                            phys    = ring_wrapped ? (cursor_line + 1 + req.row) % ROWS
                                                   : int'(req.row);
                            req.col = COL_W'($urandom_range(0, line_lens[phys]));
                        end
                    end
                    default:
                        req.op = op_t'($urandom_range(0, 3));
                endcase
                transfer_request(req, 1'b0, '0);
            end
        end
        in_ch.valid <= 1'b0;

        // Drain the pending results, then allow the pipeline to settle
        while (screen_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
